// ===== hdl/bds_pkg.sv =====
`default_nettype none

package bds_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
	localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

	localparam int PIXEL_W = 8;
	localparam int PAIR_W  = 9;
	localparam int MEAN_W  = 10;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               frame_start;
	} pix_t;

	typedef struct packed {
		logic [MEAN_W-1:0] mean_q2;
		logic              row_end;
		logic              frame_end;
	} res_t;

	// Line store command issued for one accepted pixel.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic row_end;
		logic frame_end;
	} line_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/bds_pix_if.sv =====
`default_nettype none

interface bds_pix_if;
	logic          valid;
	logic          ready;
	bds_pkg::pix_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bds_res_if.sv =====
`default_nettype none

interface bds_res_if;
	logic          valid;
	logic          ready;
	bds_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bds_ram.sv =====
`default_nettype none

module bds_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bds_scan.sv =====
`default_nettype none

module bds_scan #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      cfg_we,
	input  wire logic [bds_pkg::CFG_IDX_W-1:0]             cfg_idx,
	input  wire logic [bds_pkg::CFG_DATA_W-1:0]            cfg_data,
	input  wire logic                                      take,
	input  wire bds_pkg::pix_t                             pix,
	output bds_pkg::line_cmd_t                             cmd,
	output logic [$clog2(MAX_WIDTH / 2)-1:0]               slot,
	output logic [bds_pkg::PAIR_W-1:0]                     pair
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int AW  = $clog2(MAX_WIDTH / 2);
	localparam int WCW = $clog2(MAX_WIDTH + 1);
	localparam int HCW = $clog2(MAX_HEIGHT + 1);
	localparam int WDW = (WCW > bds_pkg::CFG_DATA_W) ? WCW : bds_pkg::CFG_DATA_W;
	localparam int HDW = (HCW > bds_pkg::CFG_DATA_W) ? HCW : bds_pkg::CFG_DATA_W;

	logic [bds_pkg::CFG_DATA_W-1:0] width_q;
	logic [bds_pkg::CFG_DATA_W-1:0] height_q;
	logic [CW-1:0]                  col_q;
	logic [RW-1:0]                  row_q;
	logic [bds_pkg::PIXEL_W-1:0]    left_q;

	logic [WDW-1:0] w_raw;
	logic [HDW-1:0] h_raw;
	logic [WDW-1:0] w_lim;
	logic [HDW-1:0] h_lim;
	logic [WDW-1:0] last_col;
	logic [HDW-1:0] last_row;
	logic [CW-1:0]  c;
	logic [RW-1:0]  r;
	logic [WDW-1:0] c_inc;
	logic [HDW-1:0] r_inc;
	logic           row_done;
	logic           frame_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bds_pkg::IMAGE_WIDTH_RST;
			height_q <= bds_pkg::IMAGE_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				bds_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				bds_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Register values out of range are clamped to the supported frame size.
	always_comb begin
		w_raw = WDW'(width_q);
		h_raw = HDW'(height_q);
		if (w_raw < WDW'(2)) begin
			w_lim = WDW'(2);
		end else if (w_raw > WDW'(MAX_WIDTH)) begin
			w_lim = WDW'(MAX_WIDTH);
		end else begin
			w_lim = w_raw;
		end
		if (h_raw < HDW'(2)) begin
			h_lim = HDW'(2);
		end else if (h_raw > HDW'(MAX_HEIGHT)) begin
			h_lim = HDW'(MAX_HEIGHT);
		end else begin
			h_lim = h_raw;
		end
		last_col = {w_lim[WDW-1:1], 1'b0} - WDW'(1);
		last_row = {h_lim[HDW-1:1], 1'b0} - HDW'(1);
	end

	always_comb begin
		c          = pix.frame_start ? '0 : col_q;
		r          = pix.frame_start ? '0 : row_q;
		c_inc      = WDW'(c) + WDW'(1);
		r_inc      = HDW'(r) + HDW'(1);
		row_done   = c_inc >= w_lim;
		frame_wrap = r_inc >= h_lim;
		slot       = AW'(c >> 1);
		pair       = bds_pkg::PAIR_W'(left_q) + bds_pkg::PAIR_W'(pix.pixel);
		cmd.wr_en     = take && c[0] && !r[0];
		cmd.rd_en     = take && c[0] && r[0];
		cmd.row_end   = WDW'(c) >= last_col;
		cmd.frame_end = (WDW'(c) >= last_col) && (HDW'(r) >= last_row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (take) begin
			if (!c[0]) begin
				left_q <= pix.pixel;
			end
			if (row_done) begin
				col_q <= '0;
				row_q <= frame_wrap ? '0 : RW'(r_inc);
			end else begin
				col_q <= CW'(c_inc);
				row_q <= r;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/box_downsample_2x2_unit.sv =====
// Averages every non-overlapping 2x2 block of an 8-bit grayscale raster stream into one
// result, the block mean in unsigned fixed point with two fraction bits; a trailing odd
// row or column is dropped. One pixel is accepted per clock cycle for as long as results
// are taken; a result that waits at the output with ready low holds off the input until
// it is taken. A result passes first through the read of the line store that holds
// the pair sums of the even row, and then through the output register. The line store
// has MAX_WIDTH/2 entries and needs no clearing after reset. Frame size is set through
// the configuration port; the user must write it only while the unit is idle, which
// the unit itself does not enforce; frame_start on a pixel restarts the position
// counters.
`default_nettype none

module box_downsample_2x2_unit #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bds_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [bds_pkg::CFG_DATA_W-1:0] cfg_data,
	bds_pix_if.sink                             pix_in,
	bds_res_if.source                           res_out
);

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int AW         = $clog2(LINE_DEPTH);

	bds_pkg::line_cmd_t          cmd;
	logic [AW-1:0]               slot;
	logic [bds_pkg::PAIR_W-1:0]  pair;
	logic [bds_pkg::PAIR_W-1:0]  line_rd;
	logic                        adv;
	logic                        take;

	logic                        valid_s1;
	logic [bds_pkg::PAIR_W-1:0]  pair_s1;
	logic                        row_end_s1;
	logic                        frame_end_s1;

	logic                        out_valid_q;
	bds_pkg::res_t               res_q;

	assign adv          = !out_valid_q || res_out.ready;
	assign take         = pix_in.valid && adv;
	assign pix_in.ready = adv;

	bds_scan #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.take     (take),
		.pix      (pix_in.data),
		.cmd      (cmd),
		.slot     (slot),
		.pair     (pair)
	);

	bds_ram #(
		.WIDTH (bds_pkg::PAIR_W),
		.DEPTH (LINE_DEPTH)
	) u_line (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (slot),
		.wr_data (pair),
		.rd_en   (cmd.rd_en),
		.rd_addr (slot),
		.rd_data (line_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pair_s1      <= pair;
			row_end_s1   <= cmd.row_end;
			frame_end_s1 <= cmd.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_q.mean_q2   <= bds_pkg::MEAN_W'(line_rd) + bds_pkg::MEAN_W'(pair_s1);
			res_q.row_end   <= row_end_s1;
			res_q.frame_end <= frame_end_s1;
		end
	end

	assign res_out.valid = out_valid_q;
	assign res_out.data  = res_q;

	a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!res_q.frame_end || res_q.row_end))
		else $error("frame end flagged on a result that does not end its row");

	a_line_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_en && cmd.rd_en))
		else $error("line store written and read for the same pixel");

	a_read_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |=> valid_s1)
		else $error("line store read lost before the sum stage");

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(pair_s1) && $stable(line_rd)))
		else $error("sum stage changed while the output was stalled");

endmodule

`default_nettype wire
